[sv/tcs_pkg.sv]
`default_nettype none

package tcs_pkg;

    localparam int RawW   = 12;
    localparam int ScrXW  = 8;
    localparam int ScrYW  = 9;
    localparam int PressW = 8;
    localparam int ThrW   = 8;
    localparam int DistW  = ScrYW + 1;

    localparam int InDataW  = 32;
    localparam int OutDataW = 32;

    // x correction: split point and the two bases
    localparam logic [RawW-1:0]   XSplit    = 12'd3000;
    localparam logic signed [RawW:0] XBaseLow  = 13'sd3870;
    localparam logic signed [RawW:0] XBaseHigh = 13'sd3800;
    localparam logic signed [RawW:0] YOffset   = 13'sd360;

    // reciprocals scaled by 2^16, exact for all 12-bit dividends here
    localparam int RecipShift = 16;
    localparam int ProdW      = 25;
    localparam logic [12:0] XRecip = 13'd4370;   // ceil(2^16 / 15)
    localparam logic [12:0] YRecip = 13'd5958;   // ceil(2^16 / 11)

    localparam logic [ScrXW-1:0] XMax = 8'd239;
    localparam logic [ScrYW-1:0] YMax = 9'd319;

    localparam logic [ThrW-1:0] ThrReset = 8'd5;

    typedef struct packed {
        logic [ScrXW-1:0] x;
        logic [ScrYW-1:0] y;
    } t_point;

endpackage

`default_nettype wire

[sv/tcs_scale.sv]
`default_nettype none

module tcs_scale (
    input  wire logic [tcs_pkg::RawW-1:0] i_raw_x,
    input  wire logic [tcs_pkg::RawW-1:0] i_raw_y,
    output tcs_pkg::t_point               o_point
);

    logic signed [tcs_pkg::RawW:0]  x_corr;
    logic signed [tcs_pkg::RawW:0]  y_corr;
    logic [tcs_pkg::ProdW-1:0]      x_prod;
    logic [tcs_pkg::ProdW-1:0]      y_prod;
    logic [tcs_pkg::ProdW-tcs_pkg::RecipShift-1:0] x_quo;
    logic [tcs_pkg::ProdW-tcs_pkg::RecipShift-1:0] y_quo;

    always_comb begin
        if (i_raw_x <= tcs_pkg::XSplit) begin
            x_corr = tcs_pkg::XBaseLow - $signed({1'b0, i_raw_x});
        end else begin
            x_corr = tcs_pkg::XBaseHigh - $signed({1'b0, i_raw_x});
        end
        y_corr = $signed({1'b0, i_raw_y}) - tcs_pkg::YOffset;
    end

    // constant divide by reciprocal multiply
    assign x_prod = tcs_pkg::ProdW'(x_corr[tcs_pkg::RawW-1:0]) * tcs_pkg::ProdW'(tcs_pkg::XRecip);
    assign y_prod = tcs_pkg::ProdW'(y_corr[tcs_pkg::RawW-1:0]) * tcs_pkg::ProdW'(tcs_pkg::YRecip);
    assign x_quo  = x_prod[tcs_pkg::ProdW-1:tcs_pkg::RecipShift];
    assign y_quo  = y_prod[tcs_pkg::ProdW-1:tcs_pkg::RecipShift];

    always_comb begin
        if (x_corr <= 0) begin
            o_point.x = '0;
        end else if (x_quo > 9'(tcs_pkg::XMax)) begin
            o_point.x = tcs_pkg::XMax;
        end else begin
            o_point.x = x_quo[tcs_pkg::ScrXW-1:0];
        end

        if (y_corr <= 0) begin
            o_point.y = '0;
        end else if (y_quo > tcs_pkg::YMax) begin
            o_point.y = tcs_pkg::YMax;
        end else begin
            o_point.y = y_quo;
        end
    end

endmodule

`default_nettype wire

[sv/touch_coordinate_scaler.sv]
`default_nettype none

// Touch sample calibration with jitter filter. Each input transfer carries
// raw 12-bit X and Y, an 8-bit pressure and the touch flag; each yields
// exactly one output transfer with the held screen position (X 0..239,
// Y 0..319), the pressure and the flag. The held position moves to a new
// touched sample only when the Manhattan distance to it is strictly greater
// than the jitter threshold written on the config port (reset value 5).
// Two register stages: scaling lands in the first, the distance test and
// held position update in the second, and one sample is taken every cycle
// while the output side keeps up.
module touch_coordinate_scaler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // raw_x, raw_y, raw_pressure
    input  wire logic        i_s_tuser,   // touch_flag
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [31:0] o_m_tdata,   // screen_x, screen_y, pressure, zero fill
    output      logic        o_m_tuser,   // touched
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);

    tcs_pkg::t_point scaled;

    logic                         r_s1_valid;
    logic                         r_s1_touch;
    tcs_pkg::t_point              r_s1_point;
    logic [tcs_pkg::PressW-1:0]   r_s1_press;

    logic                         r_out_valid;
    logic                         r_out_touch;
    logic [tcs_pkg::PressW-1:0]   r_out_press;
    tcs_pkg::t_point              r_held;
    tcs_pkg::t_point              n_held;

    logic [tcs_pkg::ThrW-1:0]     r_thr;

    logic                         s_xfer;
    logic                         out_free;
    logic                         out_load;
    logic [tcs_pkg::ScrXW-1:0]    dx;
    logic [tcs_pkg::ScrYW-1:0]    dy;
    logic [tcs_pkg::DistW-1:0]    distance;

    tcs_scale u_scale (
        .i_raw_x (i_s_tdata[11:0]),
        .i_raw_y (i_s_tdata[23:12]),
        .o_point (scaled)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign out_load   = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    always_comb begin
        dx   = (r_s1_point.x > r_held.x) ? (r_s1_point.x - r_held.x) : (r_held.x - r_s1_point.x);
        dy   = (r_s1_point.y > r_held.y) ? (r_s1_point.y - r_held.y) : (r_held.y - r_s1_point.y);
        distance = tcs_pkg::DistW'(dx) + tcs_pkg::DistW'(dy);
        if (r_s1_touch && (distance > tcs_pkg::DistW'(r_thr))) begin
            n_held = r_s1_point;
        end else begin
            n_held = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_thr       <= tcs_pkg::ThrReset;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (out_load) begin
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_touch <= i_s_tuser;
            r_s1_point <= scaled;
            r_s1_press <= i_s_tdata[31:24];
        end
        if (out_load) begin
            r_out_touch <= r_s1_touch;
            r_out_press <= r_s1_press;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_touch;
    assign o_m_tdata  = {7'd0, r_out_press, r_held.y, r_held.x};

    // no touch leaves the held position alone
    a_hold_untouched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_s1_touch) |=> (r_held == $past(r_held)))
        else $error("held position moved without touch");

    // held position never leaves the screen
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held.x <= tcs_pkg::XMax) && (r_held.y <= tcs_pkg::YMax))
        else $error("held position off screen");

    // full pipe with stalled output refuses input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while pipe full");

    // a finished sample reaches the output register in the cycle after it moves
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("output transfer lost");

endmodule

`default_nettype wire
